### hdl/dabs_pkg.sv
// package for the debounced alarm beep sequencer
// holds the alarm mode type, register indexes and reset values; no dependencies
package dabs_pkg;

  // alarm modes, coded as they appear on alarm_state
  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_LONG_BEEP = 2'd1,
    MODE_FLASH_ON  = 2'd2,
    MODE_FLASH_OFF = 2'd3
  } alarm_mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_BEEP  = 2'd1,
    REG_FLASH      = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_e;

  localparam int unsigned PressW = 8;
  localparam int unsigned PhaseW = 16;
  localparam int unsigned CfgW   = 16;

  localparam logic [PressW-1:0] PressMax        = 8'hFF;
  localparam logic [PressW-1:0] DebounceReset   = 8'd3;
  localparam logic [PhaseW-1:0] LongBeepReset   = 16'd200;
  localparam logic [PhaseW-1:0] FlashReset      = 16'd10;

endpackage

### hdl/debounced_alarm_beep_sequencer.sv
// top level of the debounced alarm beep sequencer
// debounce, start edge detect, beep/flash sequencing and result register; uses dabs_pkg
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | start_pressed_raw_i, stop_pressed_raw_i
//  out     | output    | out_valid_o / out_stall_i  | buzzer_on_o, alarm_state_o
//  cfg     | input     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// one scan tick per cycle while the input is not stalled: a transaction is processed in
// the cycle it is taken and its result shows in the result register on the next cycle
// the input is stalled only while a result waits in the result register and the output
// is stalled; a result taken in the same cycle frees the register for the next tick
// reset returns all counters to zero, the mode to idle and the configuration registers to defaults
module debounced_alarm_beep_sequencer
  import dabs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // tick input
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            start_pressed_raw_i,
  input  logic            stop_pressed_raw_i,
  // result output
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            buzzer_on_o,
  output logic [1:0]      alarm_state_o,
  // configuration writes
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [PressW-1:0] debounce_q;
  logic [PhaseW-1:0] long_beep_q;
  logic [PhaseW-1:0] flash_q;

  alarm_mode_e       mode_q, mode_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PressW-1:0] start_cnt_q, start_cnt_d;
  logic [PressW-1:0] stop_cnt_q, stop_cnt_d;
  logic              start_was_q, start_was_d;

  logic              out_valid_q, out_valid_d;
  logic              buzzer_q;
  alarm_mode_e       out_state_q;

  logic              in_take;
  logic              start_btn;
  logic              stop_btn;
  logic [PhaseW-1:0] phase_inc;
  logic [PhaseW-1:0] phase_len;

  // handshake
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign buzzer_on_o = buzzer_q;
  assign alarm_state_o = out_state_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceReset;
      long_beep_q <= LongBeepReset;
      flash_q     <= FlashReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEBOUNCE:  debounce_q  <= cfg_data_i[PressW-1:0];
        REG_LONG_BEEP: long_beep_q <= cfg_data_i[PhaseW-1:0];
        REG_FLASH:     flash_q     <= cfg_data_i[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  // press counters, saturating, cleared on release
  always_comb begin
    start_cnt_d = '0;
    if (start_pressed_raw_i) begin
      start_cnt_d = (start_cnt_q == PressMax) ? start_cnt_q : start_cnt_q + 1'b1;
    end
    stop_cnt_d = '0;
    if (stop_pressed_raw_i) begin
      stop_cnt_d = (stop_cnt_q == PressMax) ? stop_cnt_q : stop_cnt_q + 1'b1;
    end
  end

  assign start_btn = (start_cnt_d >= debounce_q);
  assign stop_btn  = (stop_cnt_d >= debounce_q);
  assign phase_inc = phase_q + 1'b1;
  assign phase_len = (mode_q == MODE_LONG_BEEP) ? long_beep_q : flash_q;

  // next mode and phase for this tick
  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    start_was_d = start_btn;
    if (stop_btn && mode_q != MODE_IDLE) begin
      mode_d  = MODE_IDLE;
      phase_d = '0;
    end else if (start_btn && !start_was_q && mode_q == MODE_IDLE) begin
      mode_d  = MODE_LONG_BEEP;
      phase_d = '0;
    end else if (mode_q != MODE_IDLE) begin
      phase_d = phase_inc;
      if (phase_inc >= phase_len) begin
        phase_d = '0;
        unique case (mode_q)
          MODE_LONG_BEEP: mode_d = MODE_FLASH_ON;
          MODE_FLASH_ON:  mode_d = MODE_FLASH_OFF;
          MODE_FLASH_OFF: mode_d = MODE_FLASH_ON;
          default:        mode_d = mode_q;
        endcase
      end
    end
  end

  // sequencer state, updated per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      phase_q     <= '0;
      start_cnt_q <= '0;
      stop_cnt_q  <= '0;
      start_was_q <= 1'b0;
    end else if (in_take) begin
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      start_cnt_q <= start_cnt_d;
      stop_cnt_q  <= stop_cnt_d;
      start_was_q <= start_was_d;
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      buzzer_q    <= (mode_d == MODE_LONG_BEEP) || (mode_d == MODE_FLASH_ON);
      out_state_q <= mode_d;
    end
  end

endmodule

### hdl/dabs_checker.sv
// port-level checks for the debounced alarm beep sequencer
// bound to the top level; uses dabs_pkg
module dabs_checker
  import dabs_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            buzzer_on_o,
  input logic [1:0]      alarm_state_o
);

  logic out_take;
  assign out_take = out_valid_o & ~out_stall_i;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input is only stalled behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // buzzer follows the reported state
  a_buzzer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> buzzer_on_o == (alarm_state_o == MODE_LONG_BEEP ||
                                     alarm_state_o == MODE_FLASH_ON))
    else $error("buzzer does not match alarm state");

  // back to back transactions: idle never jumps straight into flashing
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && $past(out_take) && $past(alarm_state_o) == MODE_IDLE
    |-> alarm_state_o == MODE_IDLE || alarm_state_o == MODE_LONG_BEEP)
    else $error("idle left for a flash phase");

  // back to back transactions: the long beep is never re-entered from flashing
  a_flash_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && $past(out_take) &&
    ($past(alarm_state_o) == MODE_FLASH_ON || $past(alarm_state_o) == MODE_FLASH_OFF)
    |-> alarm_state_o != MODE_LONG_BEEP)
    else $error("flash phase went back to long beep");

endmodule

bind debounced_alarm_beep_sequencer dabs_checker u_dabs_checker (.*);

### bench/tb_debounced_alarm_beep_sequencer.sv
// self-checking testbench for debounced_alarm_beep_sequencer
// holds a scoreboard class with its own alarm predictor; depends on dabs_pkg and the block
`timescale 1ns / 1ps

module tb_debounced_alarm_beep_sequencer;
  import dabs_pkg::*;

  localparam int unsigned LongHold   = 250;
  localparam int unsigned MaxReports = 40;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic            start_pressed_raw_i;
  logic            stop_pressed_raw_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic            buzzer_on_o;
  logic [1:0]      alarm_state_o;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  // one expected result per scan tick
  typedef struct packed {
    logic        buzzer;
    alarm_mode_e state;
  } beep_result_t;

  // alarm predictor plus the queue of results still due
  class alarm_scoreboard;
    logic [PressW-1:0] debounce_len;
    logic [PhaseW-1:0] beep_len;
    logic [PhaseW-1:0] flash_len;
    alarm_mode_e       mode;
    logic [PhaseW-1:0] phase_cnt;
    logic [PressW-1:0] start_cnt;
    logic [PressW-1:0] stop_cnt;
    bit                start_seen;
    beep_result_t      due_results[$];
    int unsigned       errors;

    function new();
      debounce_len = DebounceReset;
      beep_len     = LongBeepReset;
      flash_len    = FlashReset;
      mode         = MODE_IDLE;
      phase_cnt    = '0;
      start_cnt    = '0;
      stop_cnt     = '0;
      start_seen   = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgW-1:0] data);
      case (idx)
        REG_DEBOUNCE:  debounce_len = data[PressW-1:0];
        REG_LONG_BEEP: beep_len = data[PhaseW-1:0];
        REG_FLASH:     flash_len = data[PhaseW-1:0];
        default: ;
      endcase
    endfunction

    // press counter: saturates while held, clears on release
    function logic [PressW-1:0] bump_press(logic [PressW-1:0] cnt, bit held);
      if (!held) return '0;
      return (cnt == PressMax) ? cnt : cnt + 1'b1;
    endfunction

    // advance the alarm by one scan tick and queue its result
    function void predict_tick(bit start_raw, bit stop_raw);
      bit                start_btn;
      bit                stop_btn;
      bit                rise;
      logic [PhaseW-1:0] len;
      beep_result_t      res;
      start_cnt = bump_press(start_cnt, start_raw);
      stop_cnt  = bump_press(stop_cnt, stop_raw);
      start_btn = start_cnt >= debounce_len;
      stop_btn  = stop_cnt >= debounce_len;
      if (stop_btn && mode != MODE_IDLE) begin
        mode       = MODE_IDLE;
        phase_cnt  = '0;
        start_seen = start_btn;
      end else begin
        rise       = start_btn && !start_seen;
        start_seen = start_btn;
        if (rise && mode == MODE_IDLE) begin
          mode      = MODE_LONG_BEEP;
          phase_cnt = '0;
        end else if (mode != MODE_IDLE) begin
          phase_cnt = phase_cnt + 1'b1;
          len = (mode == MODE_LONG_BEEP) ? beep_len : flash_len;
          if (phase_cnt >= len) begin
            phase_cnt = '0;
            mode = (mode == MODE_FLASH_ON) ? MODE_FLASH_OFF : MODE_FLASH_ON;
          end
        end
      end
      res.buzzer = (mode == MODE_LONG_BEEP) || (mode == MODE_FLASH_ON);
      res.state  = mode;
      due_results.push_back(res);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxReports) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic buzzer, logic [1:0] state);
      beep_result_t exp;
      if (due_results.size() == 0) begin
        report("result with no transaction waiting");
      end else begin
        exp = due_results.pop_front();
        if (buzzer !== exp.buzzer)
          report($sformatf("buzzer_on %0b, expected %0b", buzzer, exp.buzzer));
        if (state !== exp.state)
          report($sformatf("alarm_state %0d, expected %0d", state, exp.state));
      end
    endtask
  endclass

  alarm_scoreboard sb;
  int unsigned     ticks_sent;
  bit              calm;
  bit              hold_req;

  debounced_alarm_beep_sequencer dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // idle lengths: mostly short, a few long
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned sender_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return pick_len();
  endfunction

  // receiver stall, with an occasional long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        out_stall_i = 1'b1;
        repeat (LongHold) @(negedge clk_i);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_stall_i = 1'b0;
        @(negedge clk_i);
      end else begin
        out_stall_i = 1'b1;
        repeat (pick_len()) @(negedge clk_i);
      end
    end
  end

  // result sampling
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(buzzer_on_o, alarm_state_o);
  end

  // offer one scan tick and wait until it is taken
  task automatic send_tick(input bit start_raw, input bit stop_raw);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i          = 1'b1;
    start_pressed_raw_i = start_raw;
    stop_pressed_raw_i  = stop_raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_tick(start_raw, stop_raw);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // start press, alarm run, stop press, all with random content
  task automatic alarm_episode(input int unsigned deb, input int unsigned run_max);
    repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'b0);
    repeat (deb + $urandom_range(1, 4)) send_tick(1'b1, $urandom_range(0, 7) == 0);
    repeat ($urandom_range(0, run_max)) send_tick($urandom_range(0, 9) == 0, 1'b0);
    repeat (deb + $urandom_range(1, 4)) send_tick($urandom_range(0, 3) == 0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic button_noise();
    repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // start press released before it is debounced
  task automatic short_press(input int unsigned deb);
    if (deb > 1) repeat ($urandom_range(1, deb - 1)) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic run_phase(input int unsigned deb, input int unsigned beep,
                           input int unsigned flash, input int unsigned items);
    int unsigned stop_at;
    int unsigned run_max;
    int unsigned pick;
    bit          first;
    drain_results();
    write_cfg(REG_DEBOUNCE, CfgW'(deb));
    write_cfg(REG_LONG_BEEP, CfgW'(beep));
    write_cfg(REG_FLASH, CfgW'(flash));
    run_max = beep + 3 * flash + 4;
    if (run_max > 60) run_max = 60;
    stop_at = ticks_sent + items;
    first   = 1'b1;
    while (ticks_sent < stop_at) begin
      pick  = first ? 0 : $urandom_range(0, 19);
      first = 1'b0;
      if (pick < 14) alarm_episode(deb, run_max);
      else if (pick < 17) button_noise();
      else short_press(deb);
    end
  endtask

  // stimulus
  initial begin
    sb                  = new();
    ticks_sent          = 0;
    calm                = 1'b0;
    hold_req            = 1'b0;
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    start_pressed_raw_i = 1'b0;
    stop_pressed_raw_i  = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_DEBOUNCE;
    cfg_data_i          = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: stop held while idle, start edge in the same tick
    repeat (3) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // zero debounce and zero phase lengths, unused register index
    drain_results();
    write_cfg(REG_DEBOUNCE, 16'hFF00);
    write_cfg(REG_LONG_BEEP, 16'h0000);
    write_cfg(REG_FLASH, 16'h0000);
    write_cfg(REG_UNUSED, 16'hFFFF);
    repeat (4) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);

    // one-tick phases: beep then flash toggling every tick
    drain_results();
    write_cfg(REG_DEBOUNCE, 16'h0101);
    write_cfg(REG_LONG_BEEP, 16'h0001);
    write_cfg(REG_FLASH, 16'h0001);
    send_tick(1'b1, 1'b0);
    repeat (5) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);

    // random phases over several settings, extremes included
    run_phase(1, 1, 1, 200);
    run_phase(255, 65535, 65535, 500);
    run_phase(0, 0, 0, 100);
    run_phase(2, 4, 3, 200);
    calm = 1'b1;
    run_phase($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 6), 200);
    calm = 1'b0;
    repeat (3)
      run_phase($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 6), 200);

    // receiver holds off while the sender keeps offering ticks
    drain_results();
    write_cfg(REG_DEBOUNCE, 16'd1);
    write_cfg(REG_LONG_BEEP, 16'd2);
    write_cfg(REG_FLASH, 16'd2);
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (4) alarm_episode(1, 10);
    calm = 1'b0;

    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
